[hdl/negative_base_converter_unit_assert.svh]
// Assertion macros used by the checker module of the negative-base converter.
`ifndef NEGATIVE_BASE_CONVERTER_UNIT_ASSERT_SVH
`define NEGATIVE_BASE_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define NBC_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is low.
`define NBC_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[hdl/nbc_pkg.sv]
// Types, constants and helpers of the negative-base converter.
package nbc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DIGIT_SLOTS_DEF = 34;

    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    localparam logic [3:0] BASE_MIN = 4'd2;
    localparam logic [3:0] BASE_MAX = 4'd10;

    typedef struct packed {
        logic               kind;
        logic [3:0]         base_magnitude;
        logic [3:0]         digit_in;
        logic               final_digit;
        logic signed [31:0] value_in;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [3:0]         digit_out;
        logic               last;
        logic               bad_digit;
        logic               overflow;
    } result_t;

    // Force the base magnitude into 2..10.
    function automatic logic [3:0] clamp_base(input logic [3:0] b);
        logic [3:0] r;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

[hdl/negative_base_converter_unit.sv]
// Negative-base converter: digit decoder (multiply-accumulate) and value encoder (divide unit).
//
// Usage: items enter on s_valid/s_ready with an nbc_pkg::item_t payload, results
// leave on m_valid/m_ready with an nbc_pkg::result_t payload. One item at a time.
// Decode items (kind 0) pass through the accepting state, a multiply state and
// an accumulate state; only the item flagged final_digit produces a transfer, holding
// the value and the error flags of the run, which are then cleared.
// Encode items (kind 1) run a radix-256 restoring divider over the value magnitude:
// each digit takes divider steps of eight quotient bits each, then a digit step, so a
// 32-bit value in base -2 (up to 33 digits) is divided out completely before
// the first digit goes out.
// The digits are kept in a small digit memory and sent most significant first,
// each one read through its registered read port; the last carries last = 1.
// s_ready is high only when the block is idle, so a stalled receiver holds the
// result (and the block) until the transfer completes.
// Reset (aresetn low at a clock edge) clears the accumulator, the flags, the digit
// count and the sequencer; no clearing pass is needed.
module negative_base_converter_unit #(
    parameter int VALUE_WIDTH = nbc_pkg::VALUE_WIDTH_DEF,
    parameter int DIGIT_SLOTS = nbc_pkg::DIGIT_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  nbc_pkg::item_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output nbc_pkg::result_t m_data
);
    import nbc_pkg::*;

    localparam int DIV_W     = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int DIV_STEPS = DIV_W / 8;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int IDX_W     = $clog2(DIGIT_SLOTS);
    localparam int CNT_W     = $clog2(DIGIT_SLOTS + 1);
    localparam int EXT_W     = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam int P_W       = VALUE_WIDTH + 4;

    localparam logic [VALUE_WIDTH-1:0] HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DEC_MUL = 3'd1;
    localparam logic [2:0] ST_DEC_ACC = 3'd2;
    localparam logic [2:0] ST_DIV     = 3'd3;
    localparam logic [2:0] ST_DIGIT   = 3'd4;
    localparam logic [2:0] ST_FETCH   = 3'd5;
    localparam logic [2:0] ST_SEND    = 3'd6;

    // control state
    logic [2:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   flag_bad_reg, flag_bad_next;
    logic                   flag_ovf_reg, flag_ovf_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   trunc_reg, trunc_next;
    logic                   enc_mode_reg, enc_mode_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    // payload
    logic [3:0]             b_reg, b_next;
    logic [3:0]             d_reg, d_next;
    logic                   final_reg, final_next;
    logic                   neg_reg, neg_next;
    logic [P_W-1:0]         p_reg, p_next;
    logic [31:0]            dec_value_reg, dec_value_next;
    logic                   dec_bad_reg, dec_bad_next;
    logic                   dec_ovf_reg, dec_ovf_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [3:0]             rem_reg, rem_next;
    logic                   sign_reg, sign_next;
    logic [3:0]             rd_data_reg;

    // digit memory
    logic [3:0]             digit_mem [DIGIT_SLOTS];
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [3:0]             mem_wdata;

    // datapath helpers
    logic [3:0]             base_in;
    logic [EXT_W-1:0]       value_ext;
    logic [VALUE_WIDTH-1:0] val_w;
    logic                   val_neg;
    logic [VALUE_WIDTH-1:0] val_mag;
    logic [VALUE_WIDTH-1:0] acc_mag;
    logic [P_W-1:0]         prod;
    logic [P_W-1:0]         d_ext;
    logic [P_W-1:0]         sum_pos;
    logic [P_W-1:0]         diff_neg;
    logic                   ovf_now;
    logic                   bad_now;
    logic [VALUE_WIDTH-1:0] acc_new;
    logic [EXT_W-1:0]       dec_ext;
    logic [7:0]             div_chunk;
    logic [7:0]             div_qchunk;
    logic [3:0]             div_rem;
    logic [4:0]             div_t;
    logic [DIV_W-1:0]       div_quo;
    logic [VALUE_WIDTH-1:0] qm;
    logic [3:0]             enc_digit;
    logic [VALUE_WIDTH-1:0] next_mag;
    logic                   cnt_full;
    logic [CNT_W-1:0]       cnt_after;
    logic [CNT_W-1:0]       last_pos;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_SEND);

    always_comb begin
        m_data.value_out = enc_mode_reg ? 32'sd0 : $signed(dec_value_reg);
        m_data.digit_out = enc_mode_reg ? rd_data_reg : 4'd0;
        m_data.last      = enc_mode_reg ? (rd_idx_reg == '0) : 1'b1;
        m_data.bad_digit = enc_mode_reg ? 1'b0 : dec_bad_reg;
        m_data.overflow  = enc_mode_reg ? trunc_reg : dec_ovf_reg;
    end

    // Input conditioning: base clamp for every item, value magnitude for encode items.
    always_comb begin
        base_in   = clamp_base(s_data.base_magnitude);
        value_ext = EXT_W'(s_data.value_in);
        val_w     = value_ext[VALUE_WIDTH-1:0];
        val_neg   = val_w[VALUE_WIDTH-1];
        val_mag   = val_neg ? (~val_w + 1'b1) : val_w;
    end

    // Decode datapath: magnitude times base, then signed add of the digit.
    always_comb begin
        acc_mag  = acc_reg[VALUE_WIDTH-1] ? (~acc_reg + 1'b1) : acc_reg;
        prod     = P_W'(acc_mag) * P_W'(b_reg);
        d_ext    = P_W'(d_reg);
        sum_pos  = p_reg + d_ext;
        diff_neg = d_ext - p_reg;
        if (neg_reg) begin
            ovf_now = (sum_pos >= P_W'(HALF));
            acc_new = sum_pos[VALUE_WIDTH-1:0];
        end else begin
            ovf_now = (p_reg > d_ext) && ((p_reg - d_ext) > P_W'(HALF));
            acc_new = diff_neg[VALUE_WIDTH-1:0];
        end
        bad_now = (d_reg >= b_reg);
        dec_ext = EXT_W'($signed(acc_new));
    end

    // Divider step of the encoder: eight restoring bits against the base per cycle.
    always_comb begin
        div_chunk = quo_reg[DIV_W-1 -: 8];
        div_rem   = rem_reg;
        div_t     = '0;
        for (int i = 7; i >= 0; i--) begin
            div_t = {div_rem, div_chunk[i]};
            if (div_t >= {1'b0, b_reg}) begin
                div_qchunk[i] = 1'b1;
                div_t         = div_t - {1'b0, b_reg};
            end else begin
                div_qchunk[i] = 1'b0;
            end
            div_rem = div_t[3:0];
        end
        div_quo = (quo_reg << 8) | DIV_W'(div_qchunk);
    end

    // Map the unsigned quotient and remainder onto a negative-base digit.
    always_comb begin
        qm = quo_reg[VALUE_WIDTH-1:0];
        if (sign_reg) begin
            enc_digit = (rem_reg == 4'd0) ? 4'd0 : (b_reg - rem_reg);
            next_mag  = qm + VALUE_WIDTH'(rem_reg != 4'd0);
        end else begin
            enc_digit = rem_reg;
            next_mag  = qm;
        end
        cnt_full  = (cnt_reg == CNT_W'(DIGIT_SLOTS));
        cnt_after = cnt_full ? cnt_reg : (cnt_reg + 1'b1);
        last_pos  = cnt_after - 1'b1;
    end

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        flag_bad_next  = flag_bad_reg;
        flag_ovf_next  = flag_ovf_reg;
        cnt_next       = cnt_reg;
        trunc_next     = trunc_reg;
        enc_mode_next  = enc_mode_reg;
        rd_idx_next    = rd_idx_reg;
        step_next      = step_reg;
        b_next         = b_reg;
        d_next         = d_reg;
        final_next     = final_reg;
        neg_next       = neg_reg;
        p_next         = p_reg;
        dec_value_next = dec_value_reg;
        dec_bad_next   = dec_bad_reg;
        dec_ovf_next   = dec_ovf_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        sign_next      = sign_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[IDX_W-1:0];
        mem_wdata      = enc_digit;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    b_next = base_in;
                    if (s_data.kind == KIND_DECODE) begin
                        enc_mode_next = 1'b0;
                        d_next        = s_data.digit_in;
                        final_next    = s_data.final_digit;
                        state_next    = ST_DEC_MUL;
                    end else begin
                        enc_mode_next = 1'b1;
                        trunc_next    = 1'b0;
                        if (val_w == '0) begin
                            // zero encodes as the single digit 0
                            mem_we      = 1'b1;
                            mem_waddr   = '0;
                            mem_wdata   = 4'd0;
                            cnt_next    = CNT_W'(1);
                            rd_idx_next = '0;
                            state_next  = ST_FETCH;
                        end else begin
                            quo_next   = DIV_W'(val_mag);
                            sign_next  = val_neg;
                            rem_next   = 4'd0;
                            step_next  = STEP_W'(DIV_STEPS - 1);
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DEC_MUL: begin
                p_next     = prod;
                neg_next   = acc_reg[VALUE_WIDTH-1];
                state_next = ST_DEC_ACC;
            end
            ST_DEC_ACC: begin
                if (final_reg) begin
                    dec_value_next = dec_ext[31:0];
                    dec_bad_next   = flag_bad_reg | bad_now;
                    dec_ovf_next   = flag_ovf_reg | ovf_now;
                    acc_next       = '0;
                    flag_bad_next  = 1'b0;
                    flag_ovf_next  = 1'b0;
                    state_next     = ST_SEND;
                end else begin
                    acc_next      = acc_new;
                    flag_bad_next = flag_bad_reg | bad_now;
                    flag_ovf_next = flag_ovf_reg | ovf_now;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIV: begin
                quo_next  = div_quo;
                rem_next  = div_rem;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                // keep the least significant digits, flag the rest as dropped
                if (!cnt_full) begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    trunc_next = 1'b1;
                end
                if (next_mag == '0) begin
                    rd_idx_next = last_pos[IDX_W-1:0];
                    state_next  = ST_FETCH;
                end else begin
                    quo_next   = DIV_W'(next_mag);
                    sign_next  = !sign_reg;
                    rem_next   = 4'd0;
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_FETCH: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    if (enc_mode_reg && (rd_idx_reg != '0)) begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_FETCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            flag_bad_reg <= 1'b0;
            flag_ovf_reg <= 1'b0;
            cnt_reg      <= '0;
            trunc_reg    <= 1'b0;
            enc_mode_reg <= 1'b0;
            rd_idx_reg   <= '0;
            step_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            flag_bad_reg <= flag_bad_next;
            flag_ovf_reg <= flag_ovf_next;
            cnt_reg      <= cnt_next;
            trunc_reg    <= trunc_next;
            enc_mode_reg <= enc_mode_next;
            rd_idx_reg   <= rd_idx_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg         <= b_next;
        d_reg         <= d_next;
        final_reg     <= final_next;
        neg_reg       <= neg_next;
        p_reg         <= p_next;
        dec_value_reg <= dec_value_next;
        dec_bad_reg   <= dec_bad_next;
        dec_ovf_reg   <= dec_ovf_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        sign_reg      <= sign_next;
    end

    // Digit memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= digit_mem[rd_idx_reg];
    end

endmodule

[hdl/nbc_checker.sv]
// Port-level checks of the negative-base converter and their bind.
`include "negative_base_converter_unit_assert.svh"

module nbc_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input nbc_pkg::result_t m_data
);
    import nbc_pkg::*;

    // a stalled result holds
    `NBC_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // no new item while a result is pending
    `NBC_ASSERT_IMP(a_busy_when_sending, aclk, aresetn, m_valid, !s_ready)

    // an accepted item always passes through a further state before a result shows
    `NBC_ASSERT_NXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready, !m_valid)

    // after a non-final digit transfer, fetch the next digit before anything else
    `NBC_ASSERT_NXT(a_digit_fetch, aclk, aresetn, m_valid && m_ready && !m_data.last, !s_ready && !m_valid)

    // a nonzero value only comes from a decode result
    `NBC_ASSERT_IMP(a_value_is_decode, aclk, aresetn, m_valid && (m_data.value_out != 32'sd0), m_data.last && (m_data.digit_out == 4'd0))

endmodule

bind negative_base_converter_unit nbc_checker u_nbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
